FILE: rtl/vaos_pkg.sv
// shared types and constants of the voice allocator
`default_nettype none

package vaos_pkg;

  // voice index width, wide enough for the largest supported voice count (64)
  localparam int unsigned VIDX_W  = 6;
  localparam int unsigned AGE_W   = 32;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned CFG_IDX_W = 8;

  // event kinds on the input stream
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  // actions on the output stream
  localparam logic [ACT_W-1:0] ACT_NONE       = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TUNE_PRESS = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PRESS      = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DAMPEN     = 2'd3;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST_NOTE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_NOTE = 8'd1;
  localparam logic [NOTE_W-1:0]    LOWEST_NOTE_RST  = 7'd21;
  localparam logic [NOTE_W-1:0]    HIGHEST_NOTE_RST = 7'd108;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_RESP
  } vaos_state_e;

  // broadcast update applied by every voice cell
  typedef struct packed {
    logic              tick;
    logic              press;
    logic              tune;
    logic [VIDX_W-1:0] voice;
    logic [NOTE_W-1:0] note;
  } cell_cmd_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [AGE_W-1:0]  best_age;
    logic [VIDX_W-1:0] best_idx;
    logic              hit;
    logic [VIDX_W-1:0] hit_idx;
  } scan_tok_t;

endpackage

`default_nettype wire

FILE: rtl/vaos_cell.sv
// one voice cell: age counter, owned note and one stage of the search chain
`default_nettype none

module vaos_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  vaos_pkg::cell_cmd_t          cmd_i,
  input  wire [vaos_pkg::NOTE_W-1:0]   note_i,
  input  vaos_pkg::scan_tok_t          tok_i,
  output vaos_pkg::scan_tok_t          tok_o
);
  import vaos_pkg::*;

  logic [AGE_W-1:0]  age_q, age_d;
  logic              own_vld_q, own_vld_d;
  logic [NOTE_W-1:0] own_note_q, own_note_d;
  logic              tok_vld_q;
  scan_tok_t         tok_d, tok_q;
  logic              sel;
  logic              match;

  assign sel   = (cmd_i.voice == VIDX_W'(IDX));
  assign match = own_vld_q && (own_note_q == note_i);

  always_comb begin
    age_d      = age_q;
    own_vld_d  = own_vld_q;
    own_note_d = own_note_q;
    if (cmd_i.tick && (age_q != '1)) begin
      age_d = age_q + AGE_W'(1);
    end
    if (cmd_i.press && sel) begin
      age_d = '0;
    end
    // tuning a voice replaces whatever note it held before
    if (cmd_i.tune && sel) begin
      own_vld_d  = 1'b1;
      own_note_d = cmd_i.note;
    end
  end

  always_comb begin
    tok_d = tok_i;
    // strictly greater keeps the lower index on a tie
    if (age_q > tok_i.best_age) begin
      tok_d.best_age = age_q;
      tok_d.best_idx = VIDX_W'(IDX);
    end
    if (!tok_i.hit && match) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = VIDX_W'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q     <= '0;
      own_vld_q <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      age_q     <= age_d;
      own_vld_q <= own_vld_d;
      tok_vld_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    own_note_q <= own_note_d;
    tok_q      <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_vld_q;
  end

endmodule

`default_nettype wire

FILE: rtl/vaos_ctrl.sv
// sequencer: event decode, range registers, search launch, decision and result register
`default_nettype none

module vaos_ctrl #(
  parameter int unsigned NOTES = 128
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [15:0]                      s_axis_tdata,
  input  wire [vaos_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [23:0]                     m_axis_tdata,
  output logic [vaos_pkg::ACT_W-1:0]      m_axis_tuser,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [vaos_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [vaos_pkg::NOTE_W-1:0]      cfg_data_i,
  output vaos_pkg::cell_cmd_t             cmd_o,
  output logic [vaos_pkg::NOTE_W-1:0]     note_o,
  output vaos_pkg::scan_tok_t             seed_o,
  input  vaos_pkg::scan_tok_t             last_i
);
  import vaos_pkg::*;

  vaos_state_e       state_q, state_d;
  logic [NOTE_W-1:0] lowest_q, highest_q;
  logic              is_on_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;
  logic [ACT_W-1:0]  res_act_q, res_act_d;
  logic [VIDX_W-1:0] res_voice_q, res_voice_d;
  logic [NOTE_W-1:0] res_note_q, res_note_d;
  logic [VEL_W-1:0]  res_vel_q, res_vel_d;
  logic              out_vld_q;
  logic [23:0]       out_data_q;
  logic [ACT_W-1:0]  out_act_q;
  logic              accept;
  logic              in_range;
  logic              needs_scan;
  logic              out_free;
  logic [NOTE_W-1:0] in_note;
  logic [VEL_W-1:0]  in_vel;

  assign in_note = s_axis_tdata[NOTE_W-1:0];
  assign in_vel  = s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign in_range = (in_note >= lowest_q) && (in_note <= highest_q) &&
                    ({1'b0, in_note} < 8'(NOTES));
  assign needs_scan = in_range &&
                      ((s_axis_tuser == CMD_NOTE_ON) || (s_axis_tuser == CMD_NOTE_OFF));

  // range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q  <= LOWEST_NOTE_RST;
      highest_q <= HIGHEST_NOTE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_LOWEST_NOTE) begin
        lowest_q <= cfg_data_i;
      end else if (cfg_index_i == REG_HIGHEST_NOTE) begin
        highest_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    res_act_d   = res_act_q;
    res_voice_d = res_voice_q;
    res_note_d  = res_note_q;
    res_vel_d   = res_vel_q;
    cmd_o       = '0;
    seed_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.tick  = (s_axis_tuser == CMD_TICK);
          res_act_d   = ACT_NONE;
          res_voice_d = '0;
          res_note_d  = '0;
          res_vel_d   = '0;
          state_d     = needs_scan ? ST_LAUNCH : ST_RESP;
        end
      end
      ST_LAUNCH: begin
        seed_o.valid = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_i.valid) begin
          res_note_d = note_q;
          if (is_on_q && last_i.hit) begin
            res_act_d   = ACT_PRESS;
            res_voice_d = last_i.hit_idx;
            res_vel_d   = vel_q;
            cmd_o.press = 1'b1;
            cmd_o.voice = last_i.hit_idx;
          end else if (is_on_q) begin
            res_act_d   = ACT_TUNE_PRESS;
            res_voice_d = last_i.best_idx;
            res_vel_d   = vel_q;
            cmd_o.press = 1'b1;
            cmd_o.tune  = 1'b1;
            cmd_o.voice = last_i.best_idx;
            cmd_o.note  = note_q;
          end else if (last_i.hit) begin
            res_act_d   = ACT_DAMPEN;
            res_voice_d = last_i.hit_idx;
            res_vel_d   = '0;
          end else begin
            res_act_d  = ACT_NONE;
            res_note_d = '0;
            res_vel_d  = '0;
          end
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // latched event and pending result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      // note on with zero velocity behaves as note off
      is_on_q <= (s_axis_tuser == CMD_NOTE_ON) && (in_vel != '0);
      note_q  <= in_note;
      vel_q   <= in_vel;
    end
    res_act_q   <= res_act_d;
    res_voice_q <= res_voice_d;
    res_note_q  <= res_note_d;
    res_vel_q   <= res_vel_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == ST_RESP) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESP) && out_free) begin
      out_data_q <= {7'd0, res_vel_q, res_note_q, res_voice_q[2:0]};
      out_act_q  <= res_act_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_act_q;
  assign note_o        = note_q;

  // the search token only comes out while the sequencer waits for it
  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_i.valid |-> state_q == ST_SCAN)
    else $error("search token outside scan");

  a_launch_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LAUNCH |=> state_q == ST_SCAN)
    else $error("launch not followed by scan");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_NONE) |-> m_axis_tdata == '0)
    else $error("no-action transfer carries data");

  a_dampen_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_DAMPEN) |-> m_axis_tdata[16:10] == '0)
    else $error("dampen transfer with velocity");

  a_press_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tune |-> cmd_o.press && !cmd_o.tick)
    else $error("tune without press");

endmodule

`default_nettype wire

FILE: rtl/voice_allocator_oldest_steal_core.sv
// voice allocator with oldest-voice stealing: sequencer and chain of voice cells
//
// usage
//   events enter on the s_axis stream: tuser is the kind (note on, note off,
//   sample tick), tdata carries note and velocity. every event gives exactly
//   one transfer on the m_axis stream: tuser is the action, tdata carries voice,
//   note and velocity. the cfg channel writes the lowest and highest accepted
//   note, always ready; the user must write it only while the block is idle (unchecked).
// timing
//   one event at a time. ticks, unused kinds and out-of-range notes go from
//   idle straight to the response state and then to the output register.
//   note events pass the launch and scan states, sending a search token
//   through the row of VOICES cells, one cell a cycle, before the response
//   state; s_axis_tready returns as the output register takes the result.
// reset
//   all ages cleared, no voice owns a note, range back to 21..108.
// back-pressure
//   the result waits in the output register while m_axis_tready is low; the
//   block still takes one more event and holds its result until that register is free.
`default_nettype none

module voice_allocator_oldest_steal_core #(
  parameter int unsigned VOICES = 8,
  parameter int unsigned NOTES  = 128
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // event stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [15:0]  s_axis_tdata,   // [6:0] note, [13:7] velocity, [15:14] zero
  input  wire [1:0]   s_axis_tuser,   // [1:0] cmd
  // action stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] voice, [9:3] out_note, [16:10] out_velocity
  output logic [1:0]  m_axis_tuser,   // [1:0] action
  // register writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [7:0]   cfg_index_i,
  input  wire [6:0]   cfg_data_i
);
  import vaos_pkg::*;

  cell_cmd_t         cmd;
  logic [NOTE_W-1:0] scan_note;
  // token links: entry 0 is the seed, entry VOICES leaves the last cell
  scan_tok_t         tok [VOICES+1];

  vaos_ctrl #(
    .NOTES (NOTES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_o         (cmd),
    .note_o        (scan_note),
    .seed_o        (tok[0]),
    .last_i        (tok[VOICES])
  );

  // one cell per voice; the token picks up the oldest age and any owner of the note
  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    vaos_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .note_i (scan_note),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

endmodule

`default_nettype wire
